[rtl/tkx_pkg.sv]
`default_nettype none

package tkx_pkg;

  // Store geometry; entry 127 of the table is the pointer and lives in a register
  localparam int STORE_DEPTH = 128;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam logic [ADDR_W-1:0] PTR_INDEX = ADDR_W'(STORE_DEPTH - 1);
  localparam logic [ADDR_W-1:0] KEY_LIMIT = ADDR_W'(STORE_DEPTH - 1);
  localparam logic [ADDR_W-1:0] FILL_LAST = ADDR_W'(STORE_DEPTH - 2);

  localparam int WARMUP_STEPS = 2048;
  localparam int STEP_W       = $clog2(WARMUP_STEPS + 1);

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_KEY    = 2'd1,
    OP_WARMUP = 2'd2,
    OP_DATA   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ALU_PTR,
    ALU_INC,
    ALU_XOR
  } alu_fn_t;

  typedef struct packed {
    alu_fn_t    fn;
    logic [7:0] a;
    logic [7:0] b;
  } alu_req_t;

endpackage

`default_nettype wire

[rtl/table_keystream_xor_cipher_core.sv]
`default_nettype none

// Start fills the table with one table entry written per cycle.
// Throughput: one item at a time; a generator step is a read, read,
// read-modify-write chain on the table memory, with one read and one write port.
// Reset: synchronous active-low rst_n clears the sequencer, key position, stop
// flag and output valid; table and pointer are undefined until a start fills them.
module table_keystream_xor_cipher_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_operation,
  input  wire logic [31:0] in_seed_value,
  input  wire logic [7:0]  in_key_char,
  input  wire logic [7:0]  in_data_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_data_out,
  output logic             out_key_full
);

  localparam int AW = tkx_pkg::ADDR_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FILL,
    S_KEY_RD,
    S_KEY_WR,
    S_GEN_A,
    S_GEN_B,
    S_GEN_C,
    S_DONE
  } state_t;

  state_t state_r;

  logic [31:0]                 seed_r;
  logic [7:0]                  kc_r;
  logic [7:0]                  db_r;
  logic                        is_data_r;
  logic [AW-1:0]               fill_idx_r;
  logic [AW-1:0]               key_pos_r;
  logic                        key_stop_r;
  logic [7:0]                  ptr_r;      // store entry 127
  logic [AW-1:0]               p_r;        // pointer at the start of the step
  logic [tkx_pkg::STEP_W-1:0]  steps_r;
  logic [7:0]                  res_r;

  logic                        out_valid_r;
  logic [7:0]                  out_data_out_r;
  logic                        out_key_full_r;

  logic                        accept;
  logic                        key_full;
  tkx_pkg::op_t                in_op;

  logic                        ram_wr_en;
  logic [AW-1:0]               ram_wr_addr;
  logic [7:0]                  ram_wr_data;
  logic                        ram_rd_en;
  logic [AW-1:0]               ram_rd_addr;
  logic [7:0]                  ram_rd_data;

  tkx_pkg::alu_req_t           alu_req;
  logic [7:0]                  alu_res;

  assign in_op    = tkx_pkg::op_t'(in_operation);
  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign key_full = key_stop_r || (key_pos_r >= tkx_pkg::KEY_LIMIT);

  assign out_valid    = out_valid_r;
  assign out_data_out = out_data_out_r;
  assign out_key_full = out_key_full_r;

  tkx_ram #(
    .WIDTH (8),
    .DEPTH (tkx_pkg::STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  tkx_step_unit u_step (
    .req (alu_req),
    .res (alu_res)
  );

  // Memory ports and the shared unit are steered by the sequencer state
  always_comb begin
    ram_wr_en   = 1'b0;
    ram_wr_addr = fill_idx_r;
    ram_wr_data = 8'd0;
    ram_rd_en   = 1'b0;
    ram_rd_addr = ptr_r[AW-1:0];
    alu_req.fn  = tkx_pkg::ALU_XOR;
    alu_req.a   = ram_rd_data;
    alu_req.b   = kc_r;
    unique case (state_r)
      S_FILL: begin
        // seed repeated little-endian: byte k takes seed byte k mod 4
        ram_wr_en = 1'b1;
        unique case (fill_idx_r[1:0])
          2'd0:    ram_wr_data = seed_r[7:0];
          2'd1:    ram_wr_data = seed_r[15:8];
          2'd2:    ram_wr_data = seed_r[23:16];
          default: ram_wr_data = seed_r[31:24];
        endcase
      end
      S_KEY_RD: begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = key_pos_r;
      end
      S_KEY_WR: begin
        // XOR the key character into the entry just read
        ram_wr_en   = 1'b1;
        ram_wr_addr = key_pos_r;
        ram_wr_data = alu_res;
      end
      S_GEN_A: begin
        ram_rd_en   = (steps_r != '0);
        ram_rd_addr = ptr_r[AW-1:0];
      end
      S_GEN_B: begin
        // new pointer from p + store[p], then fetch store[new];
        // entry 127 is the pointer register itself, not the memory
        alu_req.fn  = tkx_pkg::ALU_PTR;
        alu_req.a   = 8'(p_r);
        alu_req.b   = (p_r == tkx_pkg::PTR_INDEX) ? ptr_r : ram_rd_data;
        ram_rd_en   = 1'b1;
        ram_rd_addr = alu_res[AW-1:0];
      end
      S_GEN_C: begin
        // store[new] += p + 1
        alu_req.fn  = tkx_pkg::ALU_INC;
        alu_req.a   = ram_rd_data;
        alu_req.b   = 8'(p_r);
        ram_wr_en   = 1'b1;
        ram_wr_addr = ptr_r[AW-1:0];
        ram_wr_data = alu_res;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      key_pos_r   <= '0;
      key_stop_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // drop the result once the consumer takes it, unless a new one replaces it
      if (out_valid_r && !out_stall && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            seed_r     <= in_seed_value;
            kc_r       <= in_key_char;
            db_r       <= in_data_byte;
            res_r      <= 8'd0;
            is_data_r  <= 1'b0;
            fill_idx_r <= '0;
            unique case (in_op)
              tkx_pkg::OP_START: begin
                state_r <= S_FILL;
              end
              tkx_pkg::OP_KEY: begin
                if (key_full) begin
                  state_r <= S_DONE;
                end else if (in_key_char == 8'd0) begin
                  key_stop_r <= 1'b1;
                  state_r    <= S_DONE;
                end else begin
                  state_r <= S_KEY_RD;
                end
              end
              tkx_pkg::OP_WARMUP: begin
                ptr_r   <= {1'b0, ptr_r[AW-1:0]};
                steps_r <= tkx_pkg::STEP_W'(tkx_pkg::WARMUP_STEPS);
                state_r <= S_GEN_A;
              end
              tkx_pkg::OP_DATA: begin
                is_data_r <= 1'b1;
                steps_r   <= tkx_pkg::STEP_W'(1);
                state_r   <= S_GEN_A;
              end
              default: begin
                state_r <= S_DONE;
              end
            endcase
          end
        end
        S_FILL: begin
          if (fill_idx_r == tkx_pkg::FILL_LAST) begin
            ptr_r      <= seed_r[31:24];
            key_pos_r  <= '0;
            key_stop_r <= 1'b0;
            state_r    <= S_DONE;
          end else begin
            fill_idx_r <= fill_idx_r + AW'(1);
          end
        end
        S_KEY_RD: begin
          state_r <= S_KEY_WR;
        end
        S_KEY_WR: begin
          key_pos_r <= key_pos_r + AW'(1);
          state_r   <= S_DONE;
        end
        S_GEN_A: begin
          if (steps_r == '0) begin
            state_r <= S_DONE;
          end else begin
            p_r     <= ptr_r[AW-1:0];
            state_r <= S_GEN_B;
          end
        end
        S_GEN_B: begin
          ptr_r   <= {1'b0, alu_res[AW-1:0]};
          state_r <= S_GEN_C;
        end
        S_GEN_C: begin
          if (is_data_r) begin
            res_r <= db_r ^ alu_res;
          end
          steps_r <= steps_r - tkx_pkg::STEP_W'(1);
          state_r <= S_GEN_A;
        end
        S_DONE: begin
          // hold until the output register is free
          if (!out_valid_r || !out_stall) begin
            out_valid_r    <= 1'b1;
            out_data_out_r <= res_r;
            out_key_full_r <= key_full;
            state_r        <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/tkx_ram.sv]
`default_nettype none

module tkx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

[rtl/tkx_step_unit.sv]
`default_nettype none

// Shared 8-bit arithmetic for the generator and key loading
module tkx_step_unit (
  input  wire tkx_pkg::alu_req_t req,
  output logic [7:0]             res
);

  logic [7:0] sum;
  logic [tkx_pkg::ADDR_W-1:0] q;

  always_comb begin
    sum = req.a + req.b + {7'd0, (req.fn == tkx_pkg::ALU_INC)};
    q   = sum[tkx_pkg::ADDR_W-1:0];
    res = 8'd0;
    unique case (req.fn)
      tkx_pkg::ALU_PTR: begin
        // wrap the pointer slot back to entry zero
        res = (q == tkx_pkg::PTR_INDEX) ? 8'd0 : 8'(q);
      end
      tkx_pkg::ALU_INC: res = sum;
      tkx_pkg::ALU_XOR: res = req.a ^ req.b;
      default:          res = 8'd0;
    endcase
  end

endmodule

`default_nettype wire

[tb/keystream_checker.sv]
module keystream_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [1:0]  in_operation,
  input  wire logic [31:0] in_seed_value,
  input  wire logic [7:0]  in_key_char,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [7:0]  out_data_out,
  input  wire logic        out_key_full,
  output int               fail_count,
  output int               replies_pending
);
  import tkx_pkg::*;

  typedef struct packed {
    logic [7:0] data_out;
    logic       key_full;
  } cipher_reply_t;

  // Local copy of the table; entry 127 holds the generator pointer
  logic [7:0]    cipher_table [STORE_DEPTH];
  logic [6:0]    key_pos = '0;
  logic          key_stop = 1'b0;
  cipher_reply_t replies_due [$];
  int            mismatches = 0;

  initial begin
    fail_count = 0;
    replies_pending = 0;
  end

  function automatic logic key_is_full();
    return key_stop || (key_pos >= KEY_LIMIT);
  endfunction

  // One generator step: move the pointer, bump the entry it lands on
  function automatic logic [7:0] keystream_step();
    logic [6:0] p;
    logic [6:0] q;
    p = cipher_table[PTR_INDEX][6:0];
    q = p + cipher_table[p][6:0];
    if (q == PTR_INDEX) begin
      q = '0;
    end
    cipher_table[PTR_INDEX] = {1'b0, q};
    cipher_table[q] = cipher_table[q] + {1'b0, p} + 8'd1;
    return cipher_table[q];
  endfunction

  function automatic cipher_reply_t predict_reply(input op_t op, input logic [31:0] seed,
                                                  input logic [7:0] kc, input logic [7:0] db);
    cipher_reply_t r;
    logic [7:0]    discard;
    r.data_out = '0;
    case (op)
      OP_START: begin
        for (int k = 0; k < STORE_DEPTH; k++) begin
          cipher_table[k] = seed[8*(k%4) +: 8];
        end
        key_pos = '0;
        key_stop = 1'b0;
      end
      OP_KEY: begin
        if (!key_is_full()) begin
          if (kc == 8'd0) begin
            key_stop = 1'b1;
          end else begin
            cipher_table[key_pos] = cipher_table[key_pos] ^ kc;
            key_pos = key_pos + 7'd1;
          end
        end
      end
      OP_WARMUP: begin
        cipher_table[PTR_INDEX] = cipher_table[PTR_INDEX] & 8'h7f;
        repeat (WARMUP_STEPS) discard = keystream_step();
      end
      default: begin
        r.data_out = db ^ keystream_step();
      end
    endcase
    r.key_full = key_is_full();
    return r;
  endfunction

  always @(posedge clk) begin
    cipher_reply_t want;
    if (!rst_n) begin
      key_pos = '0;
      key_stop = 1'b0;
      replies_due.delete();
    end else begin
      // Retire the result transfer before predicting a new item
      if (out_valid && !out_stall) begin
        if (replies_due.size() == 0) begin
          $error("result transfer with nothing outstanding: data_out %0h key_full %0b",
                 out_data_out, out_key_full);
          mismatches++;
        end else begin
          want = replies_due.pop_front();
          if (out_data_out !== want.data_out) begin
            $error("data_out mismatch: expected %0h, got %0h", want.data_out, out_data_out);
            mismatches++;
          end
          if (out_key_full !== want.key_full) begin
            $error("key_full mismatch: expected %0b, got %0b", want.key_full, out_key_full);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        replies_due.push_back(predict_reply(op_t'(in_operation), in_seed_value,
                                            in_key_char, in_data_byte));
      end
    end
    fail_count <= mismatches;
    replies_pending <= replies_due.size();
  end

endmodule

[tb/testbench.sv]
module testbench;
  import tkx_pkg::*;

  // Total items to send (short directed part plus random sessions)
  localparam int ITEM_TARGET   = 520;
  // Items per idling phase: sender 27 / receiver 74, then swapped, then none
  localparam int PHASE_ITEMS   = 175;
  // Generous watchdog bound on the length of the whole run
  localparam int CYCLE_LIMIT   = 2_000_000;
  // Quiet cycles after the last result to catch a stray extra transfer
  localparam int SETTLE_CYCLES = 32;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_operation = OP_START;
  logic [31:0] in_seed_value = '0;
  logic [7:0]  in_key_char = '0;
  logic [7:0]  in_data_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_data_out;
  logic        out_key_full;

  int send_idle_pct = 27;
  int recv_stall_pct = 74;
  int idle_phase = 0;
  int items_sent = 0;
  int cycle_count = 0;
  int session_no = 0;
  int fail_count;
  int replies_pending;

  table_keystream_xor_cipher_core dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_seed_value(in_seed_value),
    .in_key_char  (in_key_char),
    .in_data_byte (in_data_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data_out (out_data_out),
    .out_key_full (out_key_full)
  );

  keystream_checker cipher_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_seed_value  (in_seed_value),
    .in_key_char    (in_key_char),
    .in_data_byte   (in_data_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data_out   (out_data_out),
    .out_key_full   (out_key_full),
    .fail_count     (fail_count),
    .replies_pending(replies_pending)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Receiver: stall at random, at the rate of the current phase
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Watchdog: end the run as failed once the cycle limit is reached
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Drop valid and hold off until every outstanding result has transferred.
  // The first edge lets the pending count catch up with the last transfer.
  task automatic drain_replies();
    in_valid <= 1'b0;
    @(posedge clk);
    while (replies_pending != 0) @(posedge clk);
  endtask

  // Present one item and hold it until the block takes the transfer
  task automatic send_item(input op_t op, input logic [31:0] seed,
                           input logic [7:0] kc, input logic [7:0] db);
    // Advance the idling phase once enough items went through; drain first
    // so that the switch lands on an idle block
    if (idle_phase < 2 && items_sent / PHASE_ITEMS > idle_phase) begin
      drain_replies();
      idle_phase++;
      send_idle_pct  = (idle_phase == 1) ? 74 : 0;
      recv_stall_pct = (idle_phase == 1) ? 27 : 0;
    end
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_operation  <= op;
    in_seed_value <= seed;
    in_key_char   <= kc;
    in_data_byte  <= db;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // One well-formed session: start, key, optional warm-up, then data bytes
  // with a sprinkle of arbitrary items mixed in
  task automatic run_session(input bit long_key);
    int          key_len;
    int          data_len;
    logic [31:0] seed;
    key_len  = long_key ? 127 + $urandom_range(1, 3) : $urandom_range(0, 12);
    data_len = $urandom_range(3, 20);
    case ($urandom_range(7))
      0:       seed = 32'h0000_0000;
      1:       seed = 32'hffff_ffff;
      default: seed = $urandom();
    endcase
    send_item(OP_START, seed, 8'($urandom()), 8'($urandom()));
    for (int i = 0; i < key_len; i++) begin
      send_item(OP_KEY, $urandom(), 8'($urandom_range(1, 255)), 8'($urandom()));
    end
    // End the key by a zero character half the time, then poke it again
    if ($urandom_range(1) == 0) begin
      send_item(OP_KEY, $urandom(), 8'h00, 8'($urandom()));
      repeat ($urandom_range(0, 2)) begin
        send_item(OP_KEY, $urandom(), 8'($urandom_range(1, 255)), 8'($urandom()));
      end
    end
    // Skip warm-up sometimes so data also runs on a raw, unmasked pointer
    if ($urandom_range(2) == 0) begin
      send_item(OP_WARMUP, $urandom(), 8'($urandom()), 8'($urandom()));
    end
    for (int i = 0; i < data_len; i++) begin
      if ($urandom_range(11) == 0) begin
        send_item(op_t'($urandom_range(3)), $urandom(), 8'($urandom()), 8'($urandom()));
      end else begin
        send_item(OP_DATA, $urandom(), 8'($urandom()), 8'($urandom()));
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Seed of all ones leaves the pointer at 0xff; step on it unmasked
    send_item(OP_START, 32'hffff_ffff, 8'h00, 8'h00);
    send_item(OP_DATA, 32'h0, 8'h00, 8'h00);
    send_item(OP_DATA, 32'h0, 8'h00, 8'hff);
    // Zero seed, a short key ended by a zero, then a key after the end
    send_item(OP_START, 32'h0000_0000, 8'h00, 8'h00);
    send_item(OP_KEY, 32'h0, 8'hff, 8'h00);
    send_item(OP_KEY, 32'h0, 8'h01, 8'h00);
    send_item(OP_KEY, 32'h0, 8'h80, 8'h00);
    send_item(OP_KEY, 32'h0, 8'h00, 8'h00);
    send_item(OP_KEY, 32'h0, 8'h5a, 8'h00);
    // Warm up, encrypt, warm up again on top of it
    send_item(OP_WARMUP, 32'h0, 8'h00, 8'h00);
    send_item(OP_DATA, 32'h0, 8'h00, 8'h00);
    send_item(OP_DATA, 32'h0, 8'h00, 8'hff);
    send_item(OP_WARMUP, 32'h0, 8'h00, 8'h00);
    send_item(OP_DATA, 32'h0, 8'h00, 8'ha5);
    // Pointer byte 0x80 sits above 127; use it before any warm-up
    send_item(OP_START, 32'h80ff_7f01, 8'h00, 8'h00);
    send_item(OP_KEY, 32'h0, 8'h7f, 8'h00);
    send_item(OP_DATA, 32'h0, 8'h00, 8'h3c);
    // A new start must clear a stopped key
    send_item(OP_KEY, 32'h0, 8'h00, 8'h00);
    send_item(OP_START, 32'h1234_5678, 8'h00, 8'h00);
    send_item(OP_KEY, 32'h0, 8'h11, 8'h00);
    send_item(OP_WARMUP, 32'h0, 8'h00, 8'h00);
    send_item(OP_DATA, 32'h0, 8'h00, 8'h96);

    // Hold off until the directed results are all back
    drain_replies();

    // Random sessions; the second one always runs the key to its length limit
    while (items_sent < ITEM_TARGET) begin
      run_session(session_no == 1 || $urandom_range(9) == 0);
      session_no++;
    end

    drain_replies();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
